@@ rtl/cas_pkg.sv @@
`default_nettype none

package cas_pkg;

    // Fixed field widths of the ports
    localparam int ROW_OUT_W  = 10;
    localparam int COL_OUT_W  = 8;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 11;
    localparam int GW_W       = 9;
    localparam int GH_W       = 11;
    localparam int THR_W      = 4;
    localparam int CNT_W      = 4;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT    = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_THRESHOLD = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GROW_THRESHOLD = 8'd3;

    // Reset values and grid rules
    localparam int WIDTH_RESET  = 80;
    localparam int HEIGHT_RESET = 40;
    localparam logic [THR_W-1:0] KEEP_RESET = 4'd4;
    localparam logic [THR_W-1:0] GROW_RESET = 4'd5;
    localparam int MIN_SIDE = 5;
    localparam int BAND     = 2;

    // One column of the two line stores
    typedef struct packed {
        logic upper;
        logic middle;
    } t_line_col;

    // One column of the 3x3 window
    typedef struct packed {
        logic top;
        logic mid;
        logic bot;
    } t_win_col;

endpackage

`default_nettype wire

@@ rtl/cas_if.sv @@
`default_nettype none

// Tile stream, one tile per beat
interface cas_tile_if import cas_pkg::*; ();
    logic valid;
    logic ready;
    logic tile_is_wall;

    modport source (output valid, output tile_is_wall, input ready);
    modport sink   (input valid, input tile_is_wall, output ready);
endinterface

// Smoothed result stream, one centre tile per beat
interface cas_result_if import cas_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [ROW_OUT_W-1:0] out_row;
    logic [COL_OUT_W-1:0] out_col;
    logic                 new_is_wall;
    logic                 last_cell;

    modport source (output valid, output out_row, output out_col, output new_is_wall,
                    output last_cell, input ready);
    modport sink   (input valid, input out_row, input out_col, input new_is_wall,
                    input last_cell, output ready);
endinterface

// Register write channel
interface cas_cfg_if import cas_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/cas_line_cell.sv @@
`default_nettype none

module cas_line_cell import cas_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_we,
    input  wire logic      i_bot,
    output t_line_col      o_col
);

    t_line_col r_col;
    t_line_col n_col;

    // Push the column down one row: middle moves to upper, new tile to middle
    always_comb begin
        n_col        = r_col;
        if (i_we) begin
            n_col.upper  = r_col.middle;
            n_col.middle = i_bot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

@@ rtl/cas_win_cell.sv @@
`default_nettype none

module cas_win_cell import cas_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_shift,
    input  wire t_win_col i_col,
    output t_win_col      o_col
);

    t_win_col r_col;
    t_win_col n_col;

    // Take the neighbor's column on every accepted beat
    always_comb begin
        n_col = i_shift ? i_col : r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
        end else begin
            r_col <= n_col;
        end
    end

    assign o_col = r_col;

endmodule

`default_nettype wire

@@ rtl/cave_automaton_smoothing.sv @@
// One smoothing pass of the wall/floor cave automaton over a grid streamed in raster
// order, one tile per beat on i_tile. A row of column cells holds the two previous rows,
// a chain of two window cells holds the two previous window columns, and each accepted
// tile completes the 3x3 window centred one row up and one column left. The block takes
// one tile per clock cycle; the result is registered and appears the cycle after the
// tile that completes it, and a tile is refused only while that output register holds
// a result the sink has not taken. Centres on row 0, column 0, the last row and the
// last column produce no beat; the two-tile border band comes out as wall. Line stores
// are flip-flops cleared by reset, so no clearing pass is needed. Width and height are
// saturated to [5, MAX_WIDTH] and [5, MAX_HEIGHT] when written; write registers only
// while the stream is idle.
`default_nettype none

module cave_automaton_smoothing import cas_pkg::*; #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    cas_tile_if.sink      i_tile,
    cas_result_if.source  o_res,
    cas_cfg_if.sink       i_cfg
);

    localparam int CIX_W = $clog2(MAX_WIDTH);
    localparam int CC_W  = CIX_W + 1;
    localparam int RIX_W = $clog2(MAX_HEIGHT);
    localparam int RC_W  = RIX_W + 1;
    localparam int SW_W  = (CC_W > GW_W) ? CC_W : GW_W;
    localparam int SH_W  = (RC_W > GH_W) ? RC_W : GH_W;
    localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
    localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

    // Configuration
    logic [CC_W-1:0]  r_w;
    logic [RC_W-1:0]  r_h;
    logic [THR_W-1:0] r_keep;
    logic [THR_W-1:0] r_grow;
    logic [SW_W-1:0]  w_gw_ext;
    logic [SH_W-1:0]  w_gh_ext;
    logic [CC_W-1:0]  w_gw_sat;
    logic [RC_W-1:0]  w_gh_sat;

    // Position and handshake
    logic [CIX_W-1:0] r_col_cnt;
    logic [CIX_W-1:0] n_col_cnt;
    logic [RIX_W-1:0] r_row_cnt;
    logic [RIX_W-1:0] n_row_cnt;
    logic             w_accept;
    logic [CC_W-1:0]  w_c;
    logic [RC_W-1:0]  w_r;

    // Line cells and prefetched column
    t_line_col        line_cols [MAX_WIDTH];
    t_line_col        r_rd;
    t_line_col        w_rd_next;

    // Window chain
    t_win_col         w_newcol;
    t_win_col         w_win1;
    t_win_col         w_win2;

    // Rule
    logic             w_emit;
    logic             w_inner;
    logic             w_last;
    logic [CNT_W-1:0] w_cnt;
    logic             w_wall;
    logic [RIX_W-1:0] w_cr;
    logic [CIX_W-1:0] w_cc;

    // Output register
    logic                 r_out_valid;
    logic [ROW_OUT_W-1:0] r_out_row;
    logic [COL_OUT_W-1:0] r_out_col;
    logic                 r_out_wall;
    logic                 r_out_last;

    // Saturate sizes on write
    assign w_gw_ext = SW_W'(i_cfg.data[GW_W-1:0]);
    assign w_gh_ext = SH_W'(i_cfg.data[GH_W-1:0]);

    always_comb begin
        if (w_gw_ext < SW_W'(MIN_SIDE)) begin
            w_gw_sat = CC_W'(MIN_SIDE);
        end else if (w_gw_ext > SW_W'(MAX_WIDTH)) begin
            w_gw_sat = CC_W'(MAX_WIDTH);
        end else begin
            w_gw_sat = CC_W'(w_gw_ext);
        end
        if (w_gh_ext < SH_W'(MIN_SIDE)) begin
            w_gh_sat = RC_W'(MIN_SIDE);
        end else if (w_gh_ext > SH_W'(MAX_HEIGHT)) begin
            w_gh_sat = RC_W'(MAX_HEIGHT);
        end else begin
            w_gh_sat = RC_W'(w_gh_ext);
        end
    end

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w    <= CC_W'(W_RST);
            r_h    <= RC_W'(H_RST);
            r_keep <= KEEP_RESET;
            r_grow <= GROW_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_GRID_WIDTH:     r_w    <= w_gw_sat;
                CFG_GRID_HEIGHT:    r_h    <= w_gh_sat;
                CFG_KEEP_THRESHOLD: r_keep <= i_cfg.data[THR_W-1:0];
                CFG_GROW_THRESHOLD: r_grow <= i_cfg.data[THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept while the output register is free or being drained
    assign i_tile.ready = !r_out_valid || o_res.ready;
    assign w_accept     = i_tile.valid && i_tile.ready;

    assign w_c = CC_W'(r_col_cnt);
    assign w_r = RC_W'(r_row_cnt);

    // Advance the raster position, wrapping at the grid edges
    always_comb begin
        n_col_cnt = r_col_cnt + 1'b1;
        n_row_cnt = r_row_cnt;
        if (w_c + 1'b1 >= r_w) begin
            n_col_cnt = '0;
            if (w_r + 1'b1 >= r_h) begin
                n_row_cnt = '0;
            end else begin
                n_row_cnt = r_row_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_cnt <= '0;
            r_row_cnt <= '0;
        end else if (w_accept) begin
            r_col_cnt <= n_col_cnt;
            r_row_cnt <= n_row_cnt;
        end
    end

    // Row of column cells, one per column of the widest grid
    for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_col
        cas_line_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_we    (w_accept && (r_col_cnt == CIX_W'(g))),
            .i_bot   (i_tile.tile_is_wall),
            .o_col   (line_cols[g])
        );
    end

    // Prefetch the column the next tile will land on
    assign w_rd_next = line_cols[n_col_cnt];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
        end else if (w_accept) begin
            r_rd <= w_rd_next;
        end
    end

    // Window chain: new column -> previous column -> column before that
    assign w_newcol.top = r_rd.upper;
    assign w_newcol.mid = r_rd.middle;
    assign w_newcol.bot = i_tile.tile_is_wall;

    cas_win_cell u_win1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_accept),
        .i_col   (w_newcol),
        .o_col   (w_win1)
    );

    cas_win_cell u_win2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (w_accept),
        .i_col   (w_win1),
        .o_col   (w_win2)
    );

    // Decide emission, border band and last centre
    assign w_emit  = (w_r >= RC_W'(BAND)) && (w_c >= CC_W'(BAND))
                  && (w_r < r_h) && (w_c < r_w);
    assign w_inner = (w_r >= RC_W'(BAND + 1)) && (w_c >= CC_W'(BAND + 1))
                  && (w_r + RC_W'(BAND - 1) < r_h) && (w_c + CC_W'(BAND - 1) < r_w);
    assign w_last  = (w_r == r_h - 1'b1) && (w_c == r_w - 1'b1);

    // Count the eight wall neighbours and apply the keep/grow rule
    assign w_cnt = CNT_W'(w_win1.top) + CNT_W'(w_win1.bot)
                 + CNT_W'(w_win2.top) + CNT_W'(w_win2.mid) + CNT_W'(w_win2.bot)
                 + CNT_W'(w_newcol.top) + CNT_W'(w_newcol.mid) + CNT_W'(w_newcol.bot);

    always_comb begin
        if (!w_inner) begin
            w_wall = 1'b1;
        end else if (w_win1.mid) begin
            w_wall = (w_cnt >= r_keep);
        end else begin
            w_wall = (w_cnt >= r_grow);
        end
    end

    assign w_cr = r_row_cnt - 1'b1;
    assign w_cc = r_col_cnt - 1'b1;

    // Output register: load on an emitting beat, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= w_emit;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_emit) begin
            r_out_row  <= ROW_OUT_W'(w_cr);
            r_out_col  <= COL_OUT_W'(w_cc);
            r_out_wall <= w_wall;
            r_out_last <= w_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_row     = r_out_row;
    assign o_res.out_col     = r_out_col;
    assign o_res.new_is_wall = r_out_wall;
    assign o_res.last_cell   = r_out_last;

endmodule

`default_nettype wire

@@ rtl/cas_checker.sv @@
`default_nettype none

module cas_checker import cas_pkg::*; (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_tile_ready,
    input wire logic                 i_res_valid,
    input wire logic                 i_res_ready,
    input wire logic [ROW_OUT_W-1:0] i_res_row,
    input wire logic [COL_OUT_W-1:0] i_res_col,
    input wire logic                 i_res_wall,
    input wire logic                 i_res_last
);

    // Hold a stalled result beat
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_row)
            && $stable(i_res_col) && $stable(i_res_wall) && $stable(i_res_last))
        else $error("result beat changed while stalled");

    // No result right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid after reset");

    // A stalled output register blocks the tile stream
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |-> !i_tile_ready)
        else $error("tile accepted while result stalled");

    // Row 1 and column 1 lie in the border band and come out as wall
    a_band_wall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_row == ROW_OUT_W'(1) || i_res_col == COL_OUT_W'(1))
            |-> i_res_wall)
        else $error("border band tile not wall");

    // Row 0 and column 0 are never emitted
    a_no_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (i_res_row != '0) && (i_res_col != '0))
        else $error("outer edge tile emitted");

endmodule

bind cave_automaton_smoothing cas_checker u_cas_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_tile_ready (i_tile.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_row    (o_res.out_row),
    .i_res_col    (o_res.out_col),
    .i_res_wall   (o_res.new_is_wall),
    .i_res_last   (o_res.last_cell)
);

`default_nettype wire

@@ dv/cave_automaton_smoothing_test.sv @@
`timescale 1ns / 1ps

module cave_automaton_smoothing_test;
    import cas_pkg::*;

    localparam int GRID_MAX_W   = 256;
    localparam int GRID_MAX_H   = 1024;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE       = 4;
    localparam int END_SETTLE   = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 2000;
    localparam int PRINT_CAP    = 100;

    // 5x5 grid: a floor centre ringed by eight walls, raster order from the left
    localparam logic [0:24] RING_GRID = 25'b10101_01110_11011_01110_10101;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
        logic                 wall;
        logic                 last;
    } t_smoothed;

    logic i_clk;
    logic i_rst_n;

    cas_tile_if   tile ();
    cas_result_if res ();
    cas_cfg_if    cfg ();

    cave_automaton_smoothing #(
        .MAX_WIDTH  (GRID_MAX_W),
        .MAX_HEIGHT (GRID_MAX_H)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tile  (tile),
        .o_res   (res),
        .i_cfg   (cfg)
    );

    // Predictor state: registers, line stores, window and raster position
    logic [GW_W-1:0]  grid_w_reg  = GW_W'(WIDTH_RESET);
    logic [GH_W-1:0]  grid_h_reg  = GH_W'(HEIGHT_RESET);
    logic [THR_W-1:0] keep_thr    = KEEP_RESET;
    logic [THR_W-1:0] grow_thr    = GROW_RESET;
    logic             upper_row_bits  [GRID_MAX_W];
    logic             middle_row_bits [GRID_MAX_W];
    t_win_col         near_col;
    t_win_col         far_col;
    int               col_cnt;
    int               row_cnt;

    t_smoothed smoothed_q[$];
    int        mismatch_count;

    // Idle controls for the sender and the receiver, one each, and the receiver hold-off request
    bit src_idle_on  = 1'b1;
    bit sink_idle_on = 1'b1;
    int hold_len;
    int hold_req;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int side_of(input int v, input int hi);
        if (v < MIN_SIDE) return MIN_SIDE;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) $display("%0t mismatch: %s", $time, what);
    endtask

    // Advance the predictor by one accepted tile; queue the centre it completes
    task automatic smooth_tile(input logic bot);
        int        w;
        int        h;
        int        c;
        int        r;
        int        cnt;
        logic      top;
        logic      mid;
        logic      wall;
        t_smoothed beat;
        w = side_of(int'(grid_w_reg), GRID_MAX_W);
        h = side_of(int'(grid_h_reg), GRID_MAX_H);
        c = col_cnt;
        r = row_cnt;
        top = upper_row_bits[c];
        mid = middle_row_bits[c];
        if (r >= 2 && c >= 2 && r < h && c < w) begin
            // border band is wall without counting
            if (r - 1 >= BAND && r - 1 + BAND < h && c - 1 >= BAND && c - 1 + BAND < w) begin
                cnt = near_col.top + near_col.bot + far_col.top + far_col.mid + far_col.bot
                    + top + mid + bot;
                wall = near_col.mid ? (cnt >= int'(keep_thr)) : (cnt >= int'(grow_thr));
            end else begin
                wall = 1'b1;
            end
            beat.row  = ROW_OUT_W'(r - 1);
            beat.col  = COL_OUT_W'(c - 1);
            beat.wall = wall;
            beat.last = (r == h - 1 && c == w - 1);
            smoothed_q.push_back(beat);
        end
        upper_row_bits[c]  = mid;
        middle_row_bits[c] = bot;
        far_col      = near_col;
        near_col.top = top;
        near_col.mid = mid;
        near_col.bot = bot;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_cnt = c;
        row_cnt = r;
    endtask

    // Send one tile beat, with an optional idle burst ahead of it
    task automatic send_tile(input logic wall);
        int gap;
        gap = (src_idle_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 17) : 0;
        if (gap > 0) begin
            tile.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        tile.valid        <= 1'b1;
        tile.tile_is_wall <= wall;
        do @(posedge i_clk); while (!tile.ready);
        smooth_tile(wall);
    endtask

    task automatic send_random_tiles(input int count, input int wall_pct);
        repeat (count) send_tile($urandom_range(0, 99) < wall_pct);
    endtask

    // Feed random tiles until the raster position is back at the grid origin
    task automatic flush_to_grid_start(input int wall_pct);
        while (row_cnt != 0 || col_cnt != 0) send_tile($urandom_range(0, 99) < wall_pct);
    endtask

    // Drop valid and hold until every expected centre has come out
    task automatic wait_results_done(input int settle);
        tile.valid <= 1'b0;
        while (smoothed_q.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge i_clk); while (!cfg.ready);
        case (idx)
            CFG_GRID_WIDTH:     grid_w_reg = data[GW_W-1:0];
            CFG_GRID_HEIGHT:    grid_h_reg = data[GH_W-1:0];
            CFG_KEEP_THRESHOLD: keep_thr   = data[THR_W-1:0];
            CFG_GROW_THRESHOLD: grow_thr   = data[THR_W-1:0];
            default: ;
        endcase
    endtask

    // Write all four registers plus one unused index, back to back
    task automatic set_grid(input logic [CFG_DATA_W-1:0] w_data, input logic [CFG_DATA_W-1:0] h_data,
                            input logic [CFG_DATA_W-1:0] keep_data,
                            input logic [CFG_DATA_W-1:0] grow_data);
        write_reg(CFG_GRID_WIDTH, w_data);
        write_reg(CFG_GRID_HEIGHT, h_data);
        write_reg(CFG_KEEP_THRESHOLD, keep_data);
        write_reg(CFG_GROW_THRESHOLD, grow_data);
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_GROW_THRESHOLD) + 1, 255)),
                  CFG_DATA_W'($urandom));
        cfg.valid <= 1'b0;
    endtask

    // Mostly 0..8, sometimes any 4-bit value; upper data bits are noise
    function automatic logic [CFG_DATA_W-1:0] pick_thr();
        logic [THR_W-1:0] thr;
        thr = ($urandom_range(0, 3) == 0) ? THR_W'($urandom) : THR_W'($urandom_range(0, 8));
        return {(CFG_DATA_W - THR_W)'($urandom), thr};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_width();
        return {(CFG_DATA_W - GW_W)'($urandom), GW_W'($urandom_range(0, 12))};
    endfunction

    // Smallest grid, ring of walls around a floor centre, zero keep and full grow
    task automatic test_ring_grid();
        set_grid(CFG_DATA_W'(MIN_SIDE), CFG_DATA_W'(MIN_SIDE), CFG_DATA_W'(0), CFG_DATA_W'(8));
        flush_to_grid_start(50);
        for (int i = 0; i < MIN_SIDE * MIN_SIDE; i++) send_tile(RING_GRID[i]);
    endtask

    // Small random grids and thresholds; phases end mid-grid on purpose
    task automatic test_random_settings();
        repeat (8) begin
            wait_results_done(SETTLE);
            set_grid(pick_width(), CFG_DATA_W'($urandom_range(0, 10)), pick_thr(), pick_thr());
            send_random_tiles($urandom_range(15, 30), $urandom_range(15, 85));
        end
    endtask

    // Long receiver hold-off against a busy sender, then a full pause mid-stream
    task automatic test_backpressure();
        src_idle_on = 1'b0;
        hold_len = HOLD_CYCLES;
        hold_req++;
        send_random_tiles(50, 50);
        src_idle_on = 1'b1;
        send_random_tiles(15, 60);
        wait_results_done(SETTLE);
        send_random_tiles(15, 40);
    endtask

    // Width saturated at the top end, minimum height, raster position kept
    task automatic test_widest_grid();
        wait_results_done(SETTLE);
        set_grid(CFG_DATA_W'(11'h7FF), CFG_DATA_W'(MIN_SIDE), pick_thr(), pick_thr());
        send_random_tiles(30, 55);
    endtask

    // Width below the minimum with ignored high bits, height saturated
    task automatic test_tallest_grid();
        wait_results_done(SETTLE);
        set_grid(CFG_DATA_W'(11'h602), CFG_DATA_W'(11'h7FF), pick_thr(), pick_thr());
        send_random_tiles(50, 45);
    endtask

    // Back-to-back beats, no idling on either side
    task automatic test_steady_stream();
        wait_results_done(SETTLE);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        set_grid(pick_width(), CFG_DATA_W'($urandom_range(5, 12)), pick_thr(), pick_thr());
        send_random_tiles(60, 50);
    endtask

    // Result ready: idle bursts, plus the long hold-off on request
    initial begin
        int hold_seen;
        int hold_left;
        int stall_left;
        hold_seen  = 0;
        hold_left  = 0;
        stall_left = 0;
        res.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req != hold_seen) begin
                hold_seen = hold_req;
                hold_left = hold_len;
            end
            if (hold_left > 0) begin
                hold_left--;
                res.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res.ready <= 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 9) == 0) begin
                stall_left = $urandom_range(1, 17) - 1;
                res.ready <= 1'b0;
            end else begin
                res.ready <= 1'b1;
            end
        end
    end

    // Compare each result beat with the oldest expected centre
    initial begin
        t_smoothed want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res.valid && res.ready) begin
                if (smoothed_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat row %0d col %0d",
                                              res.out_row, res.out_col));
                end else begin
                    want = smoothed_q.pop_front();
                    if (res.out_row !== want.row)
                        report_mismatch($sformatf("out_row %0d, want %0d", res.out_row, want.row));
                    if (res.out_col !== want.col)
                        report_mismatch($sformatf("out_col %0d, want %0d", res.out_col, want.col));
                    if (res.new_is_wall !== want.wall)
                        report_mismatch($sformatf("new_is_wall %b, want %b at (%0d,%0d)",
                                                  res.new_is_wall, want.wall, want.row, want.col));
                    if (res.last_cell !== want.last)
                        report_mismatch($sformatf("last_cell %b, want %b at (%0d,%0d)",
                                                  res.last_cell, want.last, want.row, want.col));
                end
            end
        end
    end

    // End the run when no beat moves on any channel for too long
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((tile.valid && tile.ready) || (res.valid && res.ready) || (cfg.valid && cfg.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        tile.valid        <= 1'b0;
        tile.tile_is_wall <= 1'b0;
        cfg.valid         <= 1'b0;
        cfg.index         <= CFG_GRID_WIDTH;
        cfg.data          <= '0;
        i_rst_n           <= 1'b0;
        for (int i = 0; i < GRID_MAX_W; i++) begin
            upper_row_bits[i]  = 1'b0;
            middle_row_bits[i] = 1'b0;
        end
        near_col = '0;
        far_col  = '0;
        col_cnt  = 0;
        row_cnt  = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ring_grid();
        test_random_settings();
        test_backpressure();
        test_widest_grid();
        test_tallest_grid();
        test_steady_stream();
        wait_results_done(END_SETTLE);

        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
